/* src/ffba_pkg.sv */
// Shared types and constants of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

  localparam int HEADER_BYTES     = 16;
  localparam int MAX_SEGMENTS     = 64;
  localparam int POOL_LIMIT_BYTES = 65536;
  localparam int SEG_IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int SEG_CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int SEG_SIZE_W       = 17;
  localparam int OFF_W            = 18;

  localparam logic [2:0] CMD_ALLOC   = 3'd0;
  localparam logic [2:0] CMD_CALLOC  = 3'd1;
  localparam logic [2:0] CMD_FREE    = 3'd2;
  localparam logic [2:0] CMD_REALLOC = 3'd3;
  localparam logic [2:0] CMD_INIT    = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] address;
    logic [15:0] size;
    logic [15:0] count;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] address_res;
  } rsp_t;

  typedef struct packed {
    logic                  free;
    logic [SEG_SIZE_W-1:0] size;
  } seg_t;

  typedef struct packed {
    logic                 rd_en;
    logic                 rd_bank;
    logic [SEG_IDX_W-1:0] rd_addr;
    logic                 wr_en;
    logic                 wr_bank;
    logic [SEG_IDX_W-1:0] wr_addr;
    seg_t                 wr_data;
  } tbl_ctl_t;

endpackage
`default_nettype wire

/* src/ffba_table.sv */
// Two banks of the segment table; one pass reads one bank and writes the other.
`default_nettype none
module ffba_table
  import ffba_pkg::*;
(
  input  wire logic     clk,
  input  wire tbl_ctl_t ctl,
  output seg_t          rd_data
);

  seg_t bank0 [MAX_SEGMENTS];
  seg_t bank1 [MAX_SEGMENTS];

  always_ff @(posedge clk) begin
    if (ctl.wr_en && !ctl.wr_bank) begin
      bank0[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.wr_en && ctl.wr_bank) begin
      bank1[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= ctl.rd_bank ? bank1[ctl.rd_addr] : bank0[ctl.rd_addr];
    end
  end

endmodule
`default_nettype wire

/* src/first_fit_block_allocator.sv */
// Top level of the first-fit block allocator: command sequencer over the segment table.
//
//   port group   dir  beat
//   req_*        in   command, address, size, count (req_t)
//   rsp_*        out  status, address_res (rsp_t)
//   cfg_*        in   pool_bytes write, no handshake
//
// Each pass streams the table, one entry a cycle except where a split adds a
// state, from the current bank into the other bank (2-bank ping-pong), then
// swaps banks; a realloc check pass writes nothing and keeps its bank. A pass
// runs a start state, the entries in order and a flush state. Alloc/calloc/free
// use at most one pass, realloc up to three (check, alloc, free); calloc adds a
// multiply state first, and the rsp beat is loaded in a response state.
// After rst the S_INIT state builds the initial free segment before req is taken.
// A pending rsp beat does not block the next req; rsp_stall holds only the
// hand-off of a finished result.
`default_nettype none
module first_fit_block_allocator
  import ffba_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [16:0] cfg_wdata,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire req_t        req,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output rsp_t             rsp
);

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_START = 8'b0000_1000,
    S_PROC  = 8'b0001_0000,
    S_EXTRA = 8'b0010_0000,
    S_FLUSH = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_t;

  typedef enum logic [2:0] {
    M_ALLOC = 3'b001,
    M_FREE  = 3'b010,
    M_CHECK = 3'b100
  } mode_t;

  state_t                state;
  mode_t                 mode;
  logic [16:0]           pool_bytes;
  logic                  init_rsp;
  logic [2:0]            cmd;
  logic [15:0]           addr;
  logic [15:0]           size_r;
  logic [15:0]           cnt_r;
  logic [31:0]           req_bytes;
  logic                  cur;
  logic [SEG_CNT_W-1:0]  seg_count;
  logic [SEG_CNT_W-1:0]  k;
  logic [SEG_CNT_W-1:0]  w;
  logic [OFF_W-1:0]      off;
  logic                  found;
  logic                  tfree;
  logic [SEG_SIZE_W-1:0] tsize;
  seg_t                  pend;
  logic                  pvalid;
  seg_t                  xrem;
  logic [1:0]            status;
  logic [15:0]           res;

  tbl_ctl_t              ctl;
  seg_t                  e;
  seg_t                  ep;
  logic                  hit;
  logic                  take;
  logic                  take_split;
  logic                  merge;
  logic                  emit;
  logic                  more;
  logic [16:0]           pool_clamp;
  logic [SEG_CNT_W-1:0]  k_inc;

  ffba_table u_table (
    .clk     (clk),
    .ctl     (ctl),
    .rd_data (e)
  );

  // pool size saturated into its legal range when applied
  always_comb begin
    if (pool_bytes < 17'(HEADER_BYTES + 1)) begin
      pool_clamp = 17'(HEADER_BYTES + 1);
    end else if ({15'd0, pool_bytes} > 32'(POOL_LIMIT_BYTES)) begin
      pool_clamp = 17'(POOL_LIMIT_BYTES);
    end else begin
      pool_clamp = pool_bytes;
    end
  end

  // per-entry decisions while streaming
  always_comb begin
    k_inc      = k + SEG_CNT_W'(1);
    more       = k_inc < seg_count;
    hit        = ({2'b00, addr} == off);
    take       = (mode == M_ALLOC) && !found && e.free &&
                 ({16'd0, e.size} >= {1'b0, req_bytes});
    take_split = take && (seg_count < SEG_CNT_W'(MAX_SEGMENTS)) &&
                 ({16'd0, e.size} >= ({1'b0, req_bytes} + 33'(HEADER_BYTES + 1)));
    ep = e;
    if (take) begin
      ep.free = 1'b0;
    end else if (mode == M_FREE && hit) begin
      ep.free = 1'b1;
    end
    merge = pvalid && (mode == M_FREE) && pend.free && ep.free;
    emit  = pvalid && !merge;
  end

  // table port: reads from the current bank, pass writes go to the other one
  always_comb begin
    ctl         = '0;
    ctl.rd_bank = cur;
    ctl.wr_bank = ~cur;
    ctl.wr_addr = w[SEG_IDX_W-1:0];
    ctl.wr_data = pend;
    unique case (state)
      S_INIT: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_bank = cur;
        ctl.wr_addr = '0;
        ctl.wr_data = '{free: 1'b1, size: pool_clamp - 17'(HEADER_BYTES)};
      end
      S_START: begin
        ctl.rd_en   = 1'b1;
        ctl.rd_addr = '0;
      end
      S_PROC: begin
        ctl.rd_en   = !take_split && more;
        ctl.rd_addr = k_inc[SEG_IDX_W-1:0];
        ctl.wr_en   = emit && (mode != M_CHECK);
      end
      S_EXTRA: begin
        ctl.rd_en   = k < seg_count;
        ctl.rd_addr = k[SEG_IDX_W-1:0];
        ctl.wr_en   = 1'b1;
      end
      S_FLUSH: begin
        ctl.wr_en = (mode != M_CHECK);
      end
      default: begin
      end
    endcase
  end

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      mode       <= M_ALLOC;
      pool_bytes <= 17'(POOL_LIMIT_BYTES);
      init_rsp   <= 1'b0;
      cur        <= 1'b0;
      seg_count  <= SEG_CNT_W'(1);
      rsp_valid  <= 1'b0;
      found      <= 1'b0;
      pvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        pool_bytes <= cfg_wdata;
      end
      // output register: load a finished result, or drop an accepted beat
      if (state == S_RESP && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          seg_count <= SEG_CNT_W'(1);
          state     <= init_rsp ? S_RESP : S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            cmd       <= req.command;
            addr      <= req.address;
            size_r    <= req.size;
            cnt_r     <= req.count;
            req_bytes <= {16'd0, req.size};
            status    <= ST_OK;
            res       <= '0;
            init_rsp  <= (req.command == CMD_INIT);
            case (req.command)
              CMD_ALLOC: begin
                mode  <= M_ALLOC;
                state <= S_START;
              end
              CMD_CALLOC: begin
                mode  <= M_ALLOC;
                state <= S_MUL;
              end
              CMD_FREE: begin
                mode  <= M_FREE;
                state <= (req.address == 16'd0) ? S_RESP : S_START;
              end
              CMD_REALLOC: begin
                mode  <= (req.address == 16'd0) ? M_ALLOC : M_CHECK;
                state <= S_START;
              end
              CMD_INIT: begin
                state <= S_INIT;
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end
        S_MUL: begin
          req_bytes <= 32'(size_r) * 32'(cnt_r);
          state     <= S_START;
        end
        S_START: begin
          k      <= '0;
          w      <= '0;
          off    <= OFF_W'(HEADER_BYTES);
          found  <= 1'b0;
          pvalid <= 1'b0;
          state  <= S_PROC;
        end
        S_PROC: begin
          off <= off + OFF_W'(HEADER_BYTES) + {1'b0, e.size};
          k   <= k_inc;
          if (emit) begin
            w <= w + SEG_CNT_W'(1);
          end
          if (take) begin
            found <= 1'b1;
            res   <= off[15:0];
          end
          if (hit && (mode == M_FREE || mode == M_CHECK)) begin
            found <= 1'b1;
            tsize <= e.size;
            tfree <= e.free;
          end
          pvalid <= 1'b1;
          if (take_split) begin
            // granted part goes to pend now; S_EXTRA writes it and queues the free remainder
            pend  <= '{free: 1'b0, size: req_bytes[SEG_SIZE_W-1:0]};
            xrem  <= '{free: 1'b1,
                       size: e.size - req_bytes[SEG_SIZE_W-1:0] - 17'(HEADER_BYTES)};
            state <= S_EXTRA;
          end else begin
            if (merge) begin
              pend.size <= pend.size + 17'(HEADER_BYTES) + e.size;
            end else begin
              pend <= ep;
            end
            state <= more ? S_PROC : S_FLUSH;
          end
        end
        S_EXTRA: begin
          w     <= w + SEG_CNT_W'(1);
          pend  <= xrem;
          state <= (k < seg_count) ? S_PROC : S_FLUSH;
        end
        S_FLUSH: begin
          if (mode != M_CHECK) begin
            cur       <= ~cur;
            seg_count <= w + SEG_CNT_W'(1);
          end
          unique case (mode)
            M_ALLOC: begin
              if (!found) begin
                status <= ST_NOSPACE;
                res    <= '0;
                state  <= S_RESP;
              end else if (cmd == CMD_REALLOC && addr != 16'd0) begin
                // new block granted, now release the old one
                mode  <= M_FREE;
                state <= S_START;
              end else begin
                state <= S_RESP;
              end
            end
            M_FREE: begin
              if (cmd == CMD_FREE && !found) begin
                status <= ST_BADADDR;
              end
              state <= S_RESP;
            end
            M_CHECK: begin
              if (!found || tfree) begin
                status <= ST_BADADDR;
                state  <= S_RESP;
              end else if (tsize >= {1'b0, size_r}) begin
                res   <= addr;
                state <= S_RESP;
              end else begin
                mode  <= M_ALLOC;
                state <= S_START;
              end
            end
            default: begin
              state <= S_RESP;
            end
          endcase
        end
        S_RESP: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.status      <= status;
            rsp.address_res <= res;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    seg_count != '0 && seg_count <= SEG_CNT_W'(MAX_SEGMENTS))
    else $error("segment count out of range");

  a_read_in_table: assert property (@(posedge clk) disable iff (rst)
    state == S_PROC |-> k < seg_count)
    else $error("scan past last segment");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_NOSPACE ||
                   rsp.status == ST_BADADDR))
    else $error("bad status code");
`endif

endmodule
`default_nettype wire

/* dv/first_fit_block_allocator_checker.sv */
// Checker for the first-fit block allocator: segment table predictor and result compare.
module first_fit_block_allocator_checker
  import ffba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  input  logic        req_valid,
  input  logic        req_stall,
  input  req_t        req,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_t        rsp,
  output int          fail_count,
  output int          pending
);

  logic [16:0] pool_reg;
  logic [16:0] seg_len [MAX_SEGMENTS];
  logic        seg_open [MAX_SEGMENTS];
  int          seg_num;
  rsp_t        due_q [$];

  assign pending = due_q.size();

  function automatic void pool_reset();
    int p;
    p = int'(pool_reg);
    if (p < HEADER_BYTES + 1) p = HEADER_BYTES + 1;
    if (p > POOL_LIMIT_BYTES) p = POOL_LIMIT_BYTES;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      seg_len[i] = '0;
      seg_open[i] = 1'b0;
    end
    seg_len[0] = 17'(p - HEADER_BYTES);
    seg_open[0] = 1'b1;
    seg_num = 1;
  endfunction

  function automatic int offset_of(int idx);
    int off;
    off = HEADER_BYTES;
    for (int i = 0; i < idx && i < seg_num; i++) off += HEADER_BYTES + seg_len[i];
    return off;
  endfunction

  function automatic int locate(int addr);
    int off;
    off = HEADER_BYTES;
    for (int i = 0; i < seg_num; i++) begin
      if (off == addr) return i;
      off += HEADER_BYTES + seg_len[i];
    end
    return -1;
  endfunction

  function automatic int first_fit(longint want);
    for (int i = 0; i < seg_num; i++) begin
      if (seg_open[i] && longint'(seg_len[i]) >= want) begin
        if (longint'(seg_len[i]) >= want + HEADER_BYTES + 1 && seg_num < MAX_SEGMENTS) begin
          for (int j = seg_num; j > i + 1; j--) begin
            seg_len[j] = seg_len[j-1];
            seg_open[j] = seg_open[j-1];
          end
          seg_len[i+1] = 17'(longint'(seg_len[i]) - want - HEADER_BYTES);
          seg_open[i+1] = 1'b1;
          seg_len[i] = 17'(want);
          seg_num++;
        end
        seg_open[i] = 1'b0;
        return offset_of(i);
      end
    end
    return 0;
  endfunction

  function automatic void merge_free();
    int i;
    i = 0;
    while (i + 1 < seg_num) begin
      if (seg_open[i] && seg_open[i+1]) begin
        seg_len[i] = 17'(int'(seg_len[i]) + HEADER_BYTES + int'(seg_len[i+1]));
        for (int j = i + 1; j + 1 < seg_num; j++) begin
          seg_len[j] = seg_len[j+1];
          seg_open[j] = seg_open[j+1];
        end
        seg_num--;
        seg_len[seg_num] = '0;
        seg_open[seg_num] = 1'b0;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic rsp_t serve(req_t r);
    rsp_t o;
    int   idx;
    int   got;
    o.status = ST_OK;
    o.address_res = '0;
    case (r.command)
      CMD_ALLOC, CMD_CALLOC: begin
        got = first_fit(r.command == CMD_ALLOC ? longint'(r.size)
                                               : longint'(r.size) * longint'(r.count));
        o.address_res = got[15:0];
        if (got == 0) o.status = ST_NOSPACE;
      end
      CMD_FREE: begin
        if (r.address != 0) begin
          idx = locate(r.address);
          if (idx < 0) o.status = ST_BADADDR;
          else begin
            seg_open[idx] = 1'b1;
            merge_free();
          end
        end
      end
      CMD_REALLOC: begin
        if (r.address == 0) begin
          got = first_fit(r.size);
          o.address_res = got[15:0];
          if (got == 0) o.status = ST_NOSPACE;
        end else begin
          idx = locate(r.address);
          if (idx < 0 || seg_open[idx]) o.status = ST_BADADDR;
          else if (seg_len[idx] >= r.size) o.address_res = r.address;
          else begin
            got = first_fit(r.size);
            o.address_res = got[15:0];
            if (got == 0) o.status = ST_NOSPACE;
            else begin
              idx = locate(r.address);
              if (idx >= 0) begin
                seg_open[idx] = 1'b1;
                merge_free();
              end
            end
          end
        end
      end
      CMD_INIT: pool_reset();
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      pool_reg = 17'd65536;
      pool_reset();
      due_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) pool_reg = cfg_wdata;
      if (rsp_valid && !rsp_stall) begin
        if (due_q.size() == 0) begin
          $error("unexpected result beat status=%0d address_res=%0d",
                 rsp.status, rsp.address_res);
          fail_count++;
        end else begin
          want = due_q.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            fail_count++;
          end
          if (rsp.address_res !== want.address_res) begin
            $error("address_res: expected %0d, actual %0d",
                   want.address_res, rsp.address_res);
            fail_count++;
          end
        end
      end
      if (req_valid && !req_stall) due_q.push_back(serve(req));
    end
  end

endmodule

/* dv/first_fit_block_allocator_test.sv */
// Testbench top for the first-fit block allocator: stimulus, idling and verdict.
module first_fit_block_allocator_test;
  import ffba_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  int          fail_count;
  int          pending;

  // Idling control: calm turns off all gaps for the tail of the run,
  // hold_cycles forces one long receiver hold-off.
  bit          calm = 1'b0;
  int          hold_cycles = 0;
  int          granted [$]; // live payload offsets, used to aim free/realloc

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  first_fit_block_allocator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  first_fit_block_allocator_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .fail_count(fail_count), .pending(pending)
  );

  // Track granted offsets from the result stream so free/realloc hit real blocks.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall && rsp.address_res != 0 && granted.size() < 200)
      granted.push_back(rsp.address_res);
  end

  // Receiver: random stall bursts, plus the single long hold-off on request.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
        rsp_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 11);
        rsp_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // One beat: drive at the falling edge, hold until accepted at a rising edge.
  task automatic send_beat(input logic [2:0] c, input int a, input int s, input int k);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req.command <= c;
    req.address <= a[15:0];
    req.size <= s[15:0];
    req.count <= k[15:0];
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  task automatic go_quiet();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3 * (MAX_SEGMENTS + 4) + 10) @(negedge clk);
  endtask

  task automatic set_pool(input int bytes);
    go_quiet();
    cfg_we <= 1'b1;
    cfg_wdata <= bytes[16:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    send_beat(CMD_INIT, 0, 0, 0);
    granted.delete();
  endtask

  // Address pick: mostly a live block, sometimes null or an arbitrary offset.
  function automatic int pick_addr();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7 && granted.size() > 0) return granted[$urandom_range(0, granted.size() - 1)];
    if (r == 7) return 0;
    return $urandom_range(0, 65535);
  endfunction

  // Sizes are mostly small so the table fills with many segments.
  function automatic int pick_size();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 65535);
      1, 2: return $urandom_range(0, 4096);
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  task automatic random_phase(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) send_beat(CMD_ALLOC, $urandom_range(0, 65535), pick_size(),
                            $urandom_range(0, 65535));
      else if (r < 50) send_beat(CMD_CALLOC, 0, $urandom_range(0, 64),
                                 $urandom_range(0, 64));
      else if (r < 53) send_beat(CMD_CALLOC, 0, $urandom_range(0, 65535),
                                 $urandom_range(0, 65535));
      else if (r < 80) send_beat(CMD_FREE, pick_addr(), $urandom_range(0, 65535), 0);
      else if (r < 97) send_beat(CMD_REALLOC, pick_addr(), pick_size(), 0);
      else if (r < 98) send_beat(CMD_INIT, 0, 0, 0);
      else send_beat(3'($urandom_range(5, 7)), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes and each special case on the default pool.
    send_beat(CMD_ALLOC, 0, 0, 0);               // zero-byte alloc
    send_beat(CMD_ALLOC, 16'hFFFF, 16'hFFFF, 16'hFFFF); // too big
    send_beat(CMD_ALLOC, 0, 100, 0);
    send_beat(CMD_CALLOC, 0, 16'hFFFF, 16'hFFFF); // product far beyond pool
    send_beat(CMD_CALLOC, 0, 10, 10);
    send_beat(CMD_CALLOC, 0, 0, 16'hFFFF);
    send_beat(CMD_FREE, 0, 0, 0);                // free of null
    send_beat(CMD_FREE, 16'hFFFF, 0, 0);         // unknown address
    send_beat(CMD_FREE, 48, 0, 0);               // inside the second block, not its start
    send_beat(CMD_FREE, 48, 0, 0);               // same address again
    send_beat(CMD_REALLOC, 0, 40, 0);            // realloc of null
    send_beat(CMD_REALLOC, 16, 0, 0);            // fits, kept
    send_beat(CMD_REALLOC, 16, 5000, 0);         // moves
    send_beat(CMD_REALLOC, 16, 10, 0);           // now a free segment
    send_beat(CMD_REALLOC, 16'hFFFF, 10, 0);     // unknown
    send_beat(CMD_REALLOC, 64, 16'hFFFF, 0);     // inside a block, not its start
    send_beat(3'd5, 0, 0, 0);
    send_beat(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(CMD_INIT, 0, 0, 0);

    // Fill the table to its limit with tiny blocks, then mix in random commands.
    set_pool(65536);
    for (int i = 0; i < 70; i++) send_beat(CMD_ALLOC, 0, 1, 0);
    random_phase(40);

    // Long receiver hold-off while requests keep coming.
    hold_cycles = 400;
    random_phase(60);

    set_pool(0);        // saturates to the minimum pool
    random_phase(40);
    set_pool(17);
    random_phase(40);
    set_pool(131071);   // saturates to the limit
    random_phase(300);
    set_pool(1000);
    random_phase(300);
    set_pool(20000);
    random_phase(300);
    set_pool(65536);
    random_phase(100);
    calm = 1'b1;
    random_phase(100);

    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3 * (MAX_SEGMENTS + 4) + 10) @(negedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* files.f */
src/ffba_pkg.sv
src/ffba_table.sv
src/first_fit_block_allocator.sv
dv/first_fit_block_allocator_checker.sv
dv/first_fit_block_allocator_test.sv
